// File: rtl/core/csc_pkg.sv
// Shared types, constants and helpers of the color space converter.
package csc_pkg;

    localparam int FRAC_BITS = 14;

    localparam logic signed [15:0] ONE_Q   = 16'sd1 <<< FRAC_BITS;
    localparam logic signed [15:0] HALF_Q  = ONE_Q >>> 1;
    localparam logic signed [15:0] W_RED   = 16'((3 * (1 << FRAC_BITS) + 5) / 10);
    localparam logic signed [15:0] W_GREEN = 16'((59 * (1 << FRAC_BITS) + 50) / 100);
    localparam logic signed [15:0] W_BLUE  = 16'((11 * (1 << FRAC_BITS) + 50) / 100);

    localparam logic REQ_CONVERT = 1'b0;
    localparam logic REQ_PACK    = 1'b1;

    typedef enum logic [1:0] {
        CT_TRANSP = 2'd0,
        CT_GRAY   = 2'd1,
        CT_RGB    = 2'd2,
        CT_CMYK   = 2'd3
    } t_color;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        src_type;
        logic [1:0]        dst_type;
        logic signed [15:0] comp_a;
        logic signed [15:0] comp_b;
        logic signed [15:0] comp_c;
        logic signed [15:0] comp_d;
        logic [7:0]        alpha_in;
    } t_in;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        src_type;
        logic [1:0]        dst_type;
        logic signed [15:0] comp_a;
        logic signed [15:0] comp_b;
        logic signed [15:0] comp_c;
        logic signed [15:0] comp_d;
        logic [7:0]        alpha_in;
        logic [3:0]        in_rng;
        logic signed [31:0] prod_r;
        logic signed [31:0] prod_g;
        logic signed [31:0] prod_b;
    } t_s1;

    typedef struct packed {
        logic              req_type;
        logic              transp;
        logic [7:0]        alpha_in;
        logic [1:0]        out_type;
        logic signed [15:0] res_a;
        logic signed [15:0] res_b;
        logic signed [15:0] res_c;
        logic signed [15:0] res_d;
        logic signed [15:0] ch_r;
        logic signed [15:0] ch_g;
        logic signed [15:0] ch_b;
    } t_s2;

    typedef struct packed {
        logic [1:0]        out_type;
        logic signed [15:0] res_a;
        logic signed [15:0] res_b;
        logic signed [15:0] res_c;
        logic signed [15:0] res_d;
        logic [31:0]       argb_word;
    } t_res;

    // 1.0 - min(1.0, a + b) for in-range operands
    function automatic logic [15:0] inv_clamp(input logic [14:0] a, input logic [14:0] b);
        logic [15:0] sum;
        begin
            sum = 16'(a) + 16'(b);
            if (sum >= 16'(ONE_Q)) begin
                inv_clamp = 16'd0;
            end else begin
                inv_clamp = 16'(ONE_Q) - sum;
            end
        end
    endfunction

endpackage

// File: rtl/core/csc_if.sv
// Handshake interfaces for the input and result channels of the converter.
interface csc_in_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [1:0]        src_type;
    logic [1:0]        dst_type;
    logic signed [15:0] comp_a;
    logic signed [15:0] comp_b;
    logic signed [15:0] comp_c;
    logic signed [15:0] comp_d;
    logic [7:0]        alpha_in;

    modport source (
        output valid, req_type, src_type, dst_type, comp_a, comp_b, comp_c, comp_d,
               alpha_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, src_type, dst_type, comp_a, comp_b, comp_c, comp_d,
               alpha_in,
        output ready
    );
endinterface

interface csc_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        out_type;
    logic signed [15:0] res_a;
    logic signed [15:0] res_b;
    logic signed [15:0] res_c;
    logic signed [15:0] res_d;
    logic [31:0]       argb_word;

    modport source (
        output valid, out_type, res_a, res_b, res_c, res_d, argb_word,
        input  ready
    );
    modport sink (
        input  valid, out_type, res_a, res_b, res_c, res_d, argb_word,
        output ready
    );
endinterface

// File: rtl/core/color_space_converter.sv
// Top level of the color space converter.
// Converts a color (transparent, gray, RGB or CMYK, components in signed Q2.14)
// to a target type, or packs it into a 32-bit ARGB word. Throughput is one item
// per cycle while output ready is held high; items pass through three register
// stages (weighted products, sum and conversion, byte scaling and packing), the
// last of which is the output register. Each stage takes a new item whenever it
// is empty or its content moves on, so input ready follows output ready
// combinationally through the three stages. No state is kept between items.
module color_space_converter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    csc_in_if.sink           i_in,
    csc_out_if.source        o_out
);

    csc_pkg::t_in  in_data;
    csc_pkg::t_s1  s1_data;
    csc_pkg::t_s2  s2_data;
    csc_pkg::t_res res_data;
    logic          s1_valid;
    logic          s1_ready;
    logic          s2_valid;
    logic          s2_ready;

    always_comb begin
        in_data.req_type = i_in.req_type;
        in_data.src_type = i_in.src_type;
        in_data.dst_type = i_in.dst_type;
        in_data.comp_a   = i_in.comp_a;
        in_data.comp_b   = i_in.comp_b;
        in_data.comp_c   = i_in.comp_c;
        in_data.comp_d   = i_in.comp_d;
        in_data.alpha_in = i_in.alpha_in;
    end

    csc_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_data  (in_data),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    csc_mix_stage u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    csc_pack_stage u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (res_data)
    );

    assign o_out.out_type  = res_data.out_type;
    assign o_out.res_a     = res_data.res_a;
    assign o_out.res_b     = res_data.res_b;
    assign o_out.res_c     = res_data.res_c;
    assign o_out.res_d     = res_data.res_d;
    assign o_out.argb_word = res_data.argb_word;

endmodule

// File: rtl/core/csc_mul_stage.sv
// First stage: range checks and weighted products of the components.
module csc_mul_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  csc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output csc_pkg::t_s1  o_data
);

    logic         r_valid;
    csc_pkg::t_s1 r_data;
    csc_pkg::t_s1 n_data;

    function automatic logic in_range(input logic signed [15:0] v);
        begin
            in_range = !v[15] && (v <= csc_pkg::ONE_Q);
        end
    endfunction

    always_comb begin
        n_data.req_type = i_data.req_type;
        n_data.src_type = i_data.src_type;
        n_data.dst_type = i_data.dst_type;
        n_data.comp_a   = i_data.comp_a;
        n_data.comp_b   = i_data.comp_b;
        n_data.comp_c   = i_data.comp_c;
        n_data.comp_d   = i_data.comp_d;
        n_data.alpha_in = i_data.alpha_in;
        n_data.in_rng   = {in_range(i_data.comp_d), in_range(i_data.comp_c),
                           in_range(i_data.comp_b), in_range(i_data.comp_a)};
        n_data.prod_r   = 32'(csc_pkg::W_RED) * 32'(i_data.comp_a);
        n_data.prod_g   = 32'(csc_pkg::W_GREEN) * 32'(i_data.comp_b);
        n_data.prod_b   = 32'(csc_pkg::W_BLUE) * 32'(i_data.comp_c);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: rtl/core/csc_mix_stage.sv
// Second stage: weighted sum, type conversion and RGB channels for packing.
module csc_mix_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  csc_pkg::t_s1  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output csc_pkg::t_s2  o_data
);

    logic              r_valid;
    csc_pkg::t_s2      r_data;
    csc_pkg::t_s2      n_data;
    logic signed [33:0] sum;
    logic [15:0]       gray;
    logic [15:0]       inv_a;
    logic [15:0]       inv_b;
    logic [15:0]       inv_c;
    logic [15:0]       min_ab;
    logic [15:0]       kc_a;
    logic [15:0]       kc_b;
    logic [15:0]       kc_c;
    logic [15:0]       kc_gray;
    logic              rgb_ok;
    logic              cmyk_ok;

    always_comb begin
        sum     = 34'(i_data.prod_r) + 34'(i_data.prod_g) + 34'(i_data.prod_b)
                + 34'(csc_pkg::HALF_Q);
        gray    = 16'(sum >>> csc_pkg::FRAC_BITS);
        inv_a   = 16'(csc_pkg::ONE_Q) - 16'(i_data.comp_a);
        inv_b   = 16'(csc_pkg::ONE_Q) - 16'(i_data.comp_b);
        inv_c   = 16'(csc_pkg::ONE_Q) - 16'(i_data.comp_c);
        min_ab  = (inv_a < inv_b) ? inv_a : inv_b;
        kc_a    = csc_pkg::inv_clamp(i_data.comp_a[14:0], i_data.comp_d[14:0]);
        kc_b    = csc_pkg::inv_clamp(i_data.comp_b[14:0], i_data.comp_d[14:0]);
        kc_c    = csc_pkg::inv_clamp(i_data.comp_c[14:0], i_data.comp_d[14:0]);
        kc_gray = csc_pkg::inv_clamp(gray[14:0], i_data.comp_d[14:0]);
        rgb_ok  = &i_data.in_rng[2:0];
        cmyk_ok = &i_data.in_rng;
    end

    always_comb begin
        n_data.req_type = i_data.req_type;
        n_data.transp   = (i_data.src_type == csc_pkg::CT_TRANSP);
        n_data.alpha_in = i_data.alpha_in;
        n_data.out_type = i_data.dst_type;
        n_data.res_a    = '0;
        n_data.res_b    = '0;
        n_data.res_c    = '0;
        n_data.res_d    = '0;
        n_data.ch_r     = '0;
        n_data.ch_g     = '0;
        n_data.ch_b     = '0;

        if (i_data.src_type == i_data.dst_type || i_data.src_type == csc_pkg::CT_TRANSP) begin
            n_data.out_type = i_data.src_type;
            n_data.res_a    = i_data.comp_a;
            n_data.res_b    = i_data.comp_b;
            n_data.res_c    = i_data.comp_c;
            n_data.res_d    = i_data.comp_d;
        end else if (i_data.dst_type == csc_pkg::CT_TRANSP) begin
            n_data.out_type = csc_pkg::CT_TRANSP;
        end else begin
            case (i_data.src_type)
                csc_pkg::CT_GRAY: begin
                    if (i_data.in_rng[0]) begin
                        if (i_data.dst_type == csc_pkg::CT_RGB) begin
                            n_data.res_a = i_data.comp_a;
                            n_data.res_b = i_data.comp_a;
                            n_data.res_c = i_data.comp_a;
                        end else begin
                            n_data.res_d = inv_a;
                        end
                    end
                end
                csc_pkg::CT_RGB: begin
                    if (rgb_ok) begin
                        if (i_data.dst_type == csc_pkg::CT_GRAY) begin
                            n_data.res_a = gray;
                        end else begin
                            n_data.res_a = inv_a;
                            n_data.res_b = inv_b;
                            n_data.res_c = inv_c;
                            n_data.res_d = (min_ab < inv_c) ? min_ab : inv_c;
                        end
                    end
                end
                csc_pkg::CT_CMYK: begin
                    if (cmyk_ok) begin
                        if (i_data.dst_type == csc_pkg::CT_GRAY) begin
                            n_data.res_a = kc_gray;
                        end else begin
                            n_data.res_a = kc_a;
                            n_data.res_b = kc_b;
                            n_data.res_c = kc_c;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        case (i_data.src_type)
            csc_pkg::CT_GRAY: begin
                if (i_data.in_rng[0]) begin
                    n_data.ch_r = i_data.comp_a;
                    n_data.ch_g = i_data.comp_a;
                    n_data.ch_b = i_data.comp_a;
                end
            end
            csc_pkg::CT_RGB: begin
                n_data.ch_r = i_data.comp_a;
                n_data.ch_g = i_data.comp_b;
                n_data.ch_b = i_data.comp_c;
            end
            csc_pkg::CT_CMYK: begin
                if (cmyk_ok) begin
                    n_data.ch_r = kc_a;
                    n_data.ch_g = kc_b;
                    n_data.ch_b = kc_c;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: rtl/core/csc_pack_stage.sv
// Third stage: channel scaling to bytes, ARGB packing and the output register.
module csc_pack_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  csc_pkg::t_s2  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output csc_pkg::t_res o_data
);

    logic          r_valid;
    csc_pkg::t_res r_data;
    csc_pkg::t_res n_data;

    // v * 255 >> FRAC_BITS, truncated and saturated to 0..255
    function automatic logic [7:0] chan8(input logic signed [15:0] v);
        logic [23:0] prod;
        logic [23:0] scaled;
        begin
            prod   = 24'({v[14:0], 8'h00}) - 24'(v[14:0]);
            scaled = prod >> csc_pkg::FRAC_BITS;
            if (v[15] || v == 16'sd0) begin
                chan8 = 8'd0;
            end else if (scaled > 24'd255) begin
                chan8 = 8'hFF;
            end else begin
                chan8 = scaled[7:0];
            end
        end
    endfunction

    always_comb begin
        n_data = '0;
        if (i_data.req_type == csc_pkg::REQ_PACK) begin
            if (!i_data.transp) begin
                n_data.argb_word = {i_data.alpha_in, chan8(i_data.ch_r),
                                    chan8(i_data.ch_g), chan8(i_data.ch_b)};
            end
        end else begin
            n_data.out_type = i_data.out_type;
            n_data.res_a    = i_data.res_a;
            n_data.res_b    = i_data.res_b;
            n_data.res_c    = i_data.res_c;
            n_data.res_d    = i_data.res_d;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
